@@ hdl/tpcd_pkg.sv @@
// ----------------------------------------------------------------------------
// tpcd_pkg
// Shared types and codes for the readout segment decoder.
// ----------------------------------------------------------------------------
package tpcd_pkg;

	localparam int STRIPS_PER_BOARD = 256;

	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_CLOCK   = 3'd1;
	localparam logic [2:0] KIND_SAMPLES = 3'd2;
	localparam logic [2:0] KIND_HITS    = 3'd3;
	localparam logic [2:0] KIND_DEPTH   = 3'd4;
	localparam logic [2:0] KIND_FOOTER  = 3'd5;
	localparam logic [2:0] KIND_SKIPPED = 3'd6;
	localparam logic [2:0] KIND_CLEARED = 3'd7;

	localparam logic [2:0] PH_HEADER       = 3'd0;
	localparam logic [2:0] PH_FIRST        = 3'd1;
	localparam logic [2:0] PH_SAMPLE       = 3'd2;
	localparam logic [2:0] PH_AFTER_SAMPLE = 3'd3;
	localparam logic [2:0] PH_HITS         = 3'd4;
	localparam logic [2:0] PH_FOOTER       = 3'd5;
	localparam logic [2:0] PH_SKIP         = 3'd6;

	localparam logic [1:0] REG_SAMPLER = 2'd0;
	localparam logic [1:0] REG_HIT     = 2'd1;
	localparam logic [1:0] REG_FOOTER  = 2'd2;

	localparam logic [4:0] ERR_HEADER  = 5'h01;
	localparam logic [4:0] ERR_SAMPLER = 5'h02;
	localparam logic [4:0] ERR_HIT     = 5'h04;
	localparam logic [4:0] ERR_DEPTH   = 5'h08;
	localparam logic [4:0] ERR_FOOTER  = 5'h10;

	localparam logic [12:0] CNT_MAX  = 13'h1fff;
	localparam logic [8:0]  DIST_MAX = 9'd256;

	typedef struct packed {
		logic accept;
		logic clr_step;
		logic hit_step;
		logic push;
	} tpcd_cmd_t;

	typedef struct packed {
		logic is_start;
		logic is_hit;
		logic clr_done;
		logic hit_done;
		logic out_free;
	} tpcd_sts_t;

endpackage

@@ hdl/tpcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpcd_ctrl
// Sequencer: memory clear sweeps, strip update sweep and result hand-off.
// ----------------------------------------------------------------------------
module tpcd_ctrl import tpcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  tpcd_sts_t sts,
	output tpcd_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_INIT  = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_CLEAR = 5'b00100,
		ST_HIT   = 5'b01000,
		ST_PUSH  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_INIT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.is_start) state_d = ST_CLEAR;
					else if (sts.is_hit) state_d = ST_HIT;
					else state_d = ST_PUSH;
				end
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = ST_PUSH;
			end
			ST_HIT: begin
				cmd.hit_step = 1'b1;
				if (sts.hit_done) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_INIT;
		else state_q <= state_d;
	end

endmodule

@@ hdl/tpcd_datapath.sv @@
// ----------------------------------------------------------------------------
// tpcd_datapath
// Parse state, sticky flags, strip hit counter memory and output register.
// ----------------------------------------------------------------------------
module tpcd_datapath import tpcd_pkg::*; #(
	parameter int SAMPLES_PER_CHANNEL = 1024,
	parameter int BOARDS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        opcode,
	input  logic [31:0] word,
	input  logic [1:0]  encoder_id,
	input  logic        segment_end,
	input  tpcd_cmd_t   cmd,
	output tpcd_sts_t   sts,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [2:0]  kind,
	output logic        board,
	output logic [27:0] clock_stamp,
	output logic [2:0]  sampler_channel_base,
	output logic [9:0]  sample_index,
	output logic [31:0] sample_bytes,
	output logic [9:0]  time_bucket,
	output logic [7:0]  strip_base,
	output logic [15:0] hit_mask,
	output logic [4:0]  new_strips,
	output logic [8:0]  distinct_strips,
	output logic [4:0]  error_flags
);

	localparam int DEPTH = BOARDS * STRIPS_PER_BOARD;
	localparam int AW = $clog2(DEPTH);
	localparam logic [9:0] SLAST = 10'(SAMPLES_PER_CHANNEL - 1);

	logic [19:0] smark_q, hmark_q;
	logic [31:0] fmark_q;

	logic [2:0]  phase_q;
	logic [9:0]  scnt_q;
	logic [12:0] depth_q;
	logic [4:0]  sticky_q [4];
	logic [8:0]  dist_q [BOARDS];

	logic [12:0] mem [DEPTH];
	logic [AW-1:0] clr_q;
	logic [12:0] rd_s1;
	logic [AW-1:0] addr_s1;
	logic [4:0]  step_q;

	logic [2:0]  rkind_q;
	logic        brd_q;
	logic [1:0]  enc_q;
	logic [27:0] rclk_q;
	logic [2:0]  rcbase_q;
	logic [9:0]  rsidx_q;
	logic [31:0] rsbytes_q;
	logic [9:0]  rtb_q;
	logic [7:0]  rsbase_q;
	logic [15:0] rmask_q;
	logic [4:0]  newc_q;

	logic        brd;
	logic        half;
	logic [19:0] low20;
	logic [2:0]  chip;
	logic [7:0]  sbase;
	logic [8:0]  rd_full;
	logic [AW-1:0] rd_addr;
	logic [3:0]  jj;
	logic        hbit;
	logic        wr_en;

	assign brd = (BOARDS > 1) ? encoder_id[1] : 1'b0;
	assign half = encoder_id[0];
	assign low20 = word[19:0];
	assign chip = word[28:26];
	assign sbase = {~half, chip, 4'd0};

	assign rd_full = {brd_q, rsbase_q + {4'd0, step_q[3:0]}};
	assign rd_addr = rd_full[AW-1:0];
	assign jj = step_q[3:0] - 4'd1;
	assign hbit = rmask_q[4'd15 - jj];
	assign wr_en = cmd.hit_step && (step_q != 5'd0) && hbit && (rd_s1 != CNT_MAX);

	assign sts.is_start = opcode;
	assign sts.is_hit = !opcode && (phase_q == PH_HITS) && (word[31:30] != 2'b11);
	assign sts.clr_done = &clr_q;
	assign sts.hit_done = (step_q == 5'd16);
	assign sts.out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smark_q <= '0;
			hmark_q <= '0;
			fmark_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLER: smark_q <= cfg_data[19:0];
				REG_HIT:     hmark_q <= cfg_data[19:0];
				REG_FOOTER:  fmark_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) mem[clr_q] <= '0;
		else if (wr_en) mem[addr_s1] <= rd_s1 + 13'd1;
		if (cmd.hit_step && !step_q[4]) begin
			rd_s1 <= mem[rd_addr];
			addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			scnt_q <= '0;
			depth_q <= '0;
			for (int i = 0; i < 4; i++) sticky_q[i] <= '0;
			for (int i = 0; i < BOARDS; i++) dist_q[i] <= '0;
			clr_q <= '0;
			step_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cmd.hit_step) begin
				step_q <= step_q + 5'd1;
				if (wr_en && rd_s1 == 13'd0) begin
					newc_q <= newc_q + 5'd1;
					if (dist_q[brd_q] < DIST_MAX) dist_q[brd_q] <= dist_q[brd_q] + 9'd1;
				end
			end
			if (cmd.push) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (cmd.accept) begin
				step_q <= '0;
				brd_q <= brd;
				enc_q <= encoder_id;
				rclk_q <= '0;
				rcbase_q <= '0;
				rsidx_q <= '0;
				rsbytes_q <= '0;
				rtb_q <= '0;
				rsbase_q <= '0;
				rmask_q <= '0;
				newc_q <= '0;
				rkind_q <= KIND_HEADER;
				if (opcode) begin
					rkind_q <= KIND_CLEARED;
					phase_q <= PH_HEADER;
					scnt_q <= '0;
					depth_q <= '0;
					for (int i = 0; i < 4; i++) sticky_q[i] <= '0;
					for (int i = 0; i < BOARDS; i++) dist_q[i] <= '0;
					clr_q <= '0;
				end else begin
					unique case (phase_q)
						PH_HEADER: begin
							if (scnt_q == 10'd0) begin
								if (word != 32'd1) sticky_q[encoder_id] <= sticky_q[encoder_id] | ERR_HEADER;
								scnt_q <= 10'd1;
							end else if (scnt_q == 10'd1) begin
								if (word[31:28] != 4'd4) sticky_q[encoder_id] <= sticky_q[encoder_id] | ERR_HEADER;
								scnt_q <= 10'd2;
							end else begin
								if (word[31:28] != 4'd5) sticky_q[encoder_id] <= sticky_q[encoder_id] | ERR_HEADER;
								rclk_q <= word[27:0];
								rkind_q <= KIND_CLOCK;
								scnt_q <= '0;
								phase_q <= PH_FIRST;
							end
						end
						PH_FIRST, PH_AFTER_SAMPLE, PH_FOOTER: begin
							if (phase_q == PH_FIRST && low20 == smark_q) begin
								if (word[31:20] != 12'd0) sticky_q[encoder_id] <= sticky_q[encoder_id] | ERR_SAMPLER;
								scnt_q <= '0;
								phase_q <= PH_SAMPLE;
							end else if (phase_q != PH_FOOTER && low20 == hmark_q) begin
								if (word[31:20] != 12'd0) sticky_q[encoder_id] <= sticky_q[encoder_id] | ERR_HIT;
								depth_q <= '0;
								phase_q <= PH_HITS;
							end else begin
								rkind_q <= KIND_FOOTER;
								if (word != fmark_q) begin
									sticky_q[encoder_id] <= sticky_q[encoder_id] | ERR_FOOTER;
								end
								if (word != fmark_q && low20 != 20'hfffff) begin
									phase_q <= PH_SKIP;
								end else begin
									phase_q <= PH_HEADER;
									scnt_q <= '0;
								end
							end
						end
						PH_SAMPLE: begin
							rkind_q <= KIND_SAMPLES;
							rcbase_q <= {~half, 2'b00};
							rsidx_q <= scnt_q;
							rsbytes_q <= word;
							if (scnt_q >= SLAST) begin
								phase_q <= PH_AFTER_SAMPLE;
								scnt_q <= '0;
							end else begin
								scnt_q <= scnt_q + 10'd1;
							end
						end
						PH_HITS: begin
							if (word[31:30] != 2'b11) begin
								rkind_q <= KIND_HITS;
								rtb_q <= word[9:0];
								rmask_q <= word[25:10];
								rsbase_q <= sbase;
								if (depth_q != CNT_MAX) depth_q <= depth_q + 13'd1;
							end else begin
								rkind_q <= KIND_DEPTH;
								if (word[12:0] != depth_q) sticky_q[encoder_id] <= sticky_q[encoder_id] | ERR_DEPTH;
								phase_q <= PH_FOOTER;
							end
						end
						default: begin
							rkind_q <= KIND_SKIPPED;
							if (low20 == 20'hfffff) begin
								phase_q <= PH_HEADER;
								scnt_q <= '0;
							end
						end
					endcase
					if (segment_end) begin
						phase_q <= PH_HEADER;
						scnt_q <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			kind <= rkind_q;
			board <= brd_q;
			clock_stamp <= rclk_q;
			sampler_channel_base <= rcbase_q;
			sample_index <= rsidx_q;
			sample_bytes <= rsbytes_q;
			time_bucket <= rtb_q;
			strip_base <= rsbase_q;
			hit_mask <= rmask_q;
			new_strips <= newc_q;
			distinct_strips <= dist_q[brd_q];
			error_flags <= sticky_q[enc_q];
		end
	end

endmodule

@@ hdl/tpc_readout_frame_decoder_core.sv @@
// ----------------------------------------------------------------------------
// tpc_readout_frame_decoder_core
// Readout segment decoder: header, sampler and strip hit sections, footer.
// ----------------------------------------------------------------------------
// One result word per input word. A hit word holds the input through a
// 17-step strip counter sweep over the counter memory (one read and at most
// one write a cycle, one strip per cycle) and then the hand-off; a start-event
// word holds it through the memory clear and the hand-off, other words only
// through the hand-off, which loads the output register once it is free. After
// reset and after each start-event word the counter memory, BOARDS*256 entries
// (512 by default), is cleared one entry a cycle while input is stalled;
// configuration writes are taken at any time.
module tpc_readout_frame_decoder_core import tpcd_pkg::*; #(
	parameter int SAMPLES_PER_CHANNEL = 1024,
	parameter int BOARDS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [31:0] word,
	input  logic [1:0]  encoder_id,
	input  logic        segment_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic        board,
	output logic [27:0] clock_stamp,
	output logic [2:0]  sampler_channel_base,
	output logic [9:0]  sample_index,
	output logic [31:0] sample_bytes,
	output logic [9:0]  time_bucket,
	output logic [7:0]  strip_base,
	output logic [15:0] hit_mask,
	output logic [4:0]  new_strips,
	output logic [8:0]  distinct_strips,
	output logic [4:0]  error_flags
);

	tpcd_cmd_t cmd;
	tpcd_sts_t sts;

	tpcd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .cmd(cmd)
	);

	tpcd_datapath #(
		.SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL), .BOARDS(BOARDS)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.opcode(opcode), .word(word), .encoder_id(encoder_id),
		.segment_end(segment_end), .cmd(cmd), .sts(sts),
		.out_stall(out_stall), .out_valid(out_valid), .kind(kind), .board(board),
		.clock_stamp(clock_stamp), .sampler_channel_base(sampler_channel_base),
		.sample_index(sample_index), .sample_bytes(sample_bytes),
		.time_bucket(time_bucket), .strip_base(strip_base), .hit_mask(hit_mask),
		.new_strips(new_strips), .distinct_strips(distinct_strips),
		.error_flags(error_flags)
	);

endmodule

@@ hdl/tpcd_checker.sv @@
// ----------------------------------------------------------------------------
// tpcd_checker
// Port-level checks for the readout segment decoder.
// ----------------------------------------------------------------------------
module tpcd_checker import tpcd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        opcode,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  kind,
	input logic [27:0] clock_stamp,
	input logic [4:0]  new_strips,
	input logic [8:0]  distinct_strips,
	input logic [4:0]  error_flags
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind))
		else $error("stalled result word changed");

	a_start_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode |=> in_stall)
		else $error("input taken during clear sweep");

	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_CLEARED |-> distinct_strips == 9'd0 && error_flags == 5'd0)
		else $error("cleared word shows stale state");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_HITS |-> new_strips == 5'd0 &&
			(kind == KIND_CLOCK || clock_stamp == 28'd0))
		else $error("field set outside its word kind");

endmodule

bind tpc_readout_frame_decoder_core tpcd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.opcode(opcode), .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
	.clock_stamp(clock_stamp), .new_strips(new_strips),
	.distinct_strips(distinct_strips), .error_flags(error_flags)
);

@@ bench/tb_tpc_readout_frame_decoder_core.sv @@
// ----------------------------------------------------------------------------
// tb_tpc_readout_frame_decoder_core
// Self-checking bench for the readout segment decoder. Well-formed segments
// with random content, broken segments and noise are driven through the
// valid/stall word channel. A behavioral decoder predicts every result word,
// and a monitor compares each field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_tpc_readout_frame_decoder_core;
	import tpcd_pkg::*;

	localparam int SPC = 1024;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic        op;
		logic [31:0] w;
		logic [1:0]  enc;
		logic        send;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic        board;
		logic [27:0] clk_stamp;
		logic [2:0]  cbase;
		logic [9:0]  sidx;
		logic [31:0] sbytes;
		logic [9:0]  tb;
		logic [7:0]  sbase;
		logic [15:0] hmask;
		logic [4:0]  newc;
		logic [8:0]  dstrips;
		logic [4:0]  err;
	} res_word_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_stall;
	logic opcode, segment_end;
	logic [31:0] word;
	logic [1:0] encoder_id;
	logic out_valid, out_stall;
	logic [2:0] kind;
	logic board;
	logic [27:0] clock_stamp;
	logic [2:0] sampler_channel_base;
	logic [9:0] sample_index;
	logic [31:0] sample_bytes;
	logic [9:0] time_bucket;
	logic [7:0] strip_base;
	logic [15:0] hit_mask;
	logic [4:0] new_strips;
	logic [8:0] distinct_strips;
	logic [4:0] error_flags;

	tpc_readout_frame_decoder_core DUT (.*);

	// decoder state mirror
	logic [19:0] m_sampler, m_hit;
	logic [31:0] m_footer;
	logic [2:0]  m_phase;
	int          m_scnt, m_depth;
	logic [12:0] m_strips [512];
	int          m_dist [2];
	logic [4:0]  m_err [4];

	in_word_t  pending_words[$];
	res_word_t expected_results[$];
	bit failed = 0;
	bit quiet = 0;
	int in_gap = 0, out_gap = 0, idle_cycles = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_mirror();
		m_phase = PH_HEADER;
		m_scnt = 0;
		m_depth = 0;
		foreach (m_strips[i]) m_strips[i] = '0;
		m_dist[0] = 0;
		m_dist[1] = 0;
		foreach (m_err[i]) m_err[i] = '0;
	endfunction

	function automatic logic [2:0] footer_check(logic [31:0] w, logic [1:0] e);
		if (w != m_footer) begin
			m_err[e] |= ERR_FOOTER;
			if (w[19:0] != 20'hfffff) begin
				m_phase = PH_SKIP;
				return KIND_FOOTER;
			end
		end
		m_phase = PH_HEADER;
		m_scnt = 0;
		return KIND_FOOTER;
	endfunction

	function automatic res_word_t decode_word(in_word_t it);
		res_word_t r;
		logic half, b;
		logic [2:0] chip;
		int idx;
		r = '0;
		half = it.enc[0];
		b = it.enc[1];
		r.board = b;
		if (it.op) begin
			clear_mirror();
			r.kind = KIND_CLEARED;
		end else begin
			case (m_phase)
				PH_HEADER: begin
					r.kind = KIND_HEADER;
					if (m_scnt == 0) begin
						if (it.w != 32'd1) m_err[it.enc] |= ERR_HEADER;
						m_scnt = 1;
					end else if (m_scnt == 1) begin
						if (it.w[31:28] != 4'd4) m_err[it.enc] |= ERR_HEADER;
						m_scnt = 2;
					end else begin
						if (it.w[31:28] != 4'd5) m_err[it.enc] |= ERR_HEADER;
						r.clk_stamp = it.w[27:0];
						r.kind = KIND_CLOCK;
						m_scnt = 0;
						m_phase = PH_FIRST;
					end
				end
				PH_FIRST, PH_AFTER_SAMPLE: begin
					if (m_phase == PH_FIRST && it.w[19:0] == m_sampler) begin
						if (it.w[31:20] != 0) m_err[it.enc] |= ERR_SAMPLER;
						m_scnt = 0;
						m_phase = PH_SAMPLE;
						r.kind = KIND_HEADER;
					end else if (it.w[19:0] == m_hit) begin
						if (it.w[31:20] != 0) m_err[it.enc] |= ERR_HIT;
						m_depth = 0;
						m_phase = PH_HITS;
						r.kind = KIND_HEADER;
					end else
						r.kind = footer_check(it.w, it.enc);
				end
				PH_SAMPLE: begin
					r.kind = KIND_SAMPLES;
					r.cbase = half ? 3'd0 : 3'd4;
					r.sidx = m_scnt[9:0];
					r.sbytes = it.w;
					if (m_scnt >= SPC - 1) begin
						m_phase = PH_AFTER_SAMPLE;
						m_scnt = 0;
					end else
						m_scnt = (m_scnt + 1) & 10'h3ff;
				end
				PH_HITS: begin
					if (it.w[31:30] != 2'b11) begin
						chip = it.w[28:26];
						r.kind = KIND_HITS;
						r.tb = it.w[9:0];
						r.hmask = it.w[25:10];
						r.sbase = {~half, chip, 4'd0};
						for (int j = 0; j < 16; j++)
							if (r.hmask[15-j]) begin
								idx = b * 256 + ((r.sbase + j) & 8'hff);
								if (m_strips[idx] != CNT_MAX) begin
									if (m_strips[idx] == 0) begin
										r.newc++;
										if (m_dist[b] < 256) m_dist[b]++;
									end
									m_strips[idx]++;
								end
							end
						if (m_depth < 8191) m_depth++;
					end else begin
						r.kind = KIND_DEPTH;
						if (it.w[12:0] != m_depth[12:0]) m_err[it.enc] |= ERR_DEPTH;
						m_phase = PH_FOOTER;
					end
				end
				PH_FOOTER: r.kind = footer_check(it.w, it.enc);
				default: begin
					r.kind = KIND_SKIPPED;
					if (it.w[19:0] == 20'hfffff) begin
						m_phase = PH_HEADER;
						m_scnt = 0;
					end
				end
			endcase
			if (it.send) begin
				m_phase = PH_HEADER;
				m_scnt = 0;
			end
		end
		r.dstrips = m_dist[b][8:0];
		r.err = m_err[it.enc];
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			opcode <= 0;
			word <= 0;
			encoder_id <= 0;
			segment_end <= 0;
			in_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) expected_results.push_back(decode_word({opcode, word,
				encoder_id, segment_end}));
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 0;
			end else if (pending_words.size() > 0) begin
				in_word_t it;
				it = pending_words.pop_front();
				{opcode, word, encoder_id, segment_end} <= it;
				in_valid <= 1;
				if (!quiet && $urandom_range(0, 15) == 0) in_gap <= $urandom_range(1, 13);
			end else
				in_valid <= 0;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
			out_gap <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				res_word_t got, exp_r;
				got = {kind, board, clock_stamp, sampler_channel_base, sample_index,
					sample_bytes, time_bucket, strip_base, hit_mask, new_strips,
					distinct_strips, error_flags};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					failed = 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (got !== exp_r) begin
						failed = 1;
						$display("%0t: mismatch exp kind %0d brd %0d clk %h cb %0d si %0d sb %h",
							$time, exp_r.kind, exp_r.board, exp_r.clk_stamp, exp_r.cbase,
							exp_r.sidx, exp_r.sbytes);
						$display("   tb %0d base %0d mask %h new %0d dist %0d err %h",
							exp_r.tb, exp_r.sbase, exp_r.hmask, exp_r.newc, exp_r.dstrips,
							exp_r.err);
						$display("  act kind %0d brd %0d clk %h cb %0d si %0d sb %h",
							kind, board, clock_stamp, sampler_channel_base, sample_index,
							sample_bytes);
						$display("   tb %0d base %0d mask %h new %0d dist %0d err %h",
							time_bucket, strip_base, hit_mask, new_strips, distinct_strips,
							error_flags);
					end
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				out_gap <= $urandom_range(0, 12);
				out_stall <= 1;
			end else
				out_stall <= 0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (pending_words.size() > 0 || expected_results.size() > 0 || in_valid) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic push(logic op, logic [31:0] w, logic [1:0] e, logic s);
		pending_words.push_back({op, w, e, s});
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [31:0] d);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_SAMPLER: m_sampler = d[19:0];
			REG_HIT: m_hit = d[19:0];
			default: m_footer = d;
		endcase
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd32();
		return $urandom();
	endfunction

	// one segment; flaw picks a random defect, 0 = none; short sampler runs end it early
	task automatic segment(logic [1:0] e, int flaw);
		int nsamp, nhits, tail;
		logic [31:0] w;
		push(0, flaw == 1 ? rnd32() : 32'd1, e, 0);
		push(0, {4'd4, 28'(rnd32())}, e, 0);
		push(0, {flaw == 2 ? 4'($urandom) : 4'd5, 28'($urandom)}, e, 0);
		if ($urandom_range(0, 3) == 0) begin
			push(0, {flaw == 3 ? 12'($urandom) : 12'd0, m_sampler}, e, 0);
			nsamp = $urandom_range(0, 39) == 0 ? SPC : $urandom_range(1, 6);
			for (int i = 0; i < nsamp; i++) push(0, rnd32(), e, 0);
			if (nsamp < SPC) return;
		end
		if ($urandom_range(0, 4) != 0) begin
			push(0, {flaw == 4 ? 12'($urandom) : 12'd0, m_hit}, e, 0);
			nhits = $urandom_range(0, 6);
			for (int i = 0; i < nhits; i++) begin
				w = rnd32();
				w[31:30] = 2'($urandom_range(0, 2));
				if ($urandom_range(0, 3) == 0) w[25:10] = 16'hffff;
				push(0, w, e, 0);
			end
			tail = flaw == 5 ? $urandom : nhits;
			push(0, {2'b11, 17'($urandom), 13'(tail)}, e, 0);
		end
		if (flaw == 6) begin
			w = rnd32();
			push(0, w, e, 0);
			if (w[19:0] != 20'hfffff && w != m_footer)
				for (int i = $urandom_range(0, 3); i > 0; i--)
					push(0, rnd32(), e, $urandom_range(0, 9) == 0);
			push(0, {12'($urandom), 20'hfffff}, e, 0);
		end else
			push(0, m_footer, e, flaw == 7);
	endtask

	initial begin
		int n;
		int before_sz;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_SAMPLER;
		cfg_data = 0;
		m_sampler = 0;
		m_hit = 0;
		m_footer = 0;
		clear_mirror();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		cfg_write(REG_SAMPLER, 32'h5a5a5);
		cfg_write(REG_HIT, 32'h0c0c0);
		cfg_write(REG_FOOTER, 32'hdeadbeef);

		// directed: extremes, markers with extra bits, start event
		push(0, 32'd1, 0, 0);
		push(0, 32'h4fffffff, 0, 0);
		push(0, 32'h5fffffff, 0, 0);
		push(0, 32'hfff5a5a5, 0, 0);
		push(0, 32'hffffffff, 0, 0);
		push(0, 32'h00000000, 0, 1);
		push(0, 32'hffffffff, 3, 0);
		push(0, 32'h0, 3, 0);
		push(0, 32'h0, 3, 0);
		push(0, 32'hfff0c0c0, 3, 0);
		push(0, 32'h3fffffff, 3, 0);
		push(0, 32'h1c000000, 3, 0);
		push(0, 32'hffffffff, 3, 0);
		push(0, 32'h12345678, 3, 0);
		push(0, 32'h00000000, 3, 0);
		push(0, 32'h000fffff, 3, 0);
		push(1, 32'hffffffff, 2, 1);
		push(0, 32'd1, 1, 0);
		push(0, 32'h40000000, 1, 0);
		push(0, 32'h50000000, 1, 0);
		push(0, 32'hdeadbeef, 1, 0);
		push(1, 32'h0, 0, 0);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					cfg_write(REG_SAMPLER, 32'h0);
					cfg_write(REG_HIT, 32'hfffff);
					cfg_write(REG_FOOTER, 32'h0);
				end
				1: begin
					cfg_write(REG_SAMPLER, 32'hfffff);
					cfg_write(REG_HIT, 32'h0);
					cfg_write(REG_FOOTER, 32'hffffffff);
				end
				default: begin
					cfg_write(REG_SAMPLER, $urandom_range(0, 32'hfffff));
					cfg_write(REG_HIT, $urandom_range(0, 32'hfffff));
					cfg_write(REG_FOOTER, rnd32());
				end
			endcase
			quiet = (phase == 3);
			n = 0;
			while (n < 400) begin
				before_sz = pending_words.size();
				case ($urandom_range(0, 19))
					0: push(1, rnd32(), 2'($urandom), 1'($urandom));
					1, 2: push(0, rnd32(), 2'($urandom), $urandom_range(0, 7) == 0);
					3, 4, 5: segment(2'($urandom), $urandom_range(1, 7));
					default: segment(2'($urandom), 0);
				endcase
				n = n + pending_words.size() - before_sz;
				while (pending_words.size() > 64) @(posedge clk);
			end
			drain();
		end

		if (!failed)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
